>>> rtl/core/qph_pkg.sv
// Shared types and constants for the quadratic-probe hash set.
// No dependencies; qph_store, qph_seq and quadratic_probe_hash_set_unit import this package.
`default_nettype none
package qph_pkg;

  localparam int MAX_BUCKETS_DEF = 64;
  localparam int KEY_W           = 31;
  localparam int CMD_W           = 3;
  localparam int CFG_W           = 7;
  localparam int SLOT_W          = 6;
  localparam int STATUS_W        = 2;
  localparam int COUNT_W         = 7;
  localparam int TAG_W           = 2;
  localparam int ENTRY_W         = TAG_W + KEY_W;
  localparam int IN_DATA_W       = 40;
  localparam int OUT_DATA_W      = 16;
  localparam int DIV_STEPS       = KEY_W;
  localparam int BITCNT_W        = 5;
  localparam logic [CFG_W-1:0] CAP_RESET = 7'd17;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT   = 3'd0,
    CMD_REMOVE   = 3'd1,
    CMD_CONTAINS = 3'd2,
    CMD_SEARCH   = 3'd3,
    CMD_CLEAR    = 3'd4
  } cmd_t;

  typedef enum logic [TAG_W-1:0] {
    TAG_EMPTY   = 2'd0,
    TAG_DELETED = 2'd1,
    TAG_LIVE    = 2'd2
  } tag_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    SQ_INIT,
    SQ_IDLE,
    SQ_DIV,
    SQ_READ,
    SQ_CHECK,
    SQ_CLEAR,
    SQ_DONE
  } seq_state_t;

  // Result word, found in the lowest bit
  typedef struct packed {
    logic [COUNT_W-1:0]  entry_count;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic                found;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/core/qph_modstep.sv
// Shared compare-and-subtract unit: y = (a >= m) ? a - m : a.
// Used for long-division remainder steps and probe address wraps. No dependencies.
`default_nettype none
module qph_modstep #(
  parameter int CW = 7
) (
  input  wire logic [CW:0]   a,
  input  wire logic [CW-1:0] m,
  output logic      [CW-1:0] y
);
  logic [CW:0] diff;

  // one subtract, select on borrow
  always_comb begin
    diff = a - {1'b0, m};
    if (a >= {1'b0, m}) begin
      y = diff[CW-1:0];
    end else begin
      y = a[CW-1:0];
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/qph_store.sv
// Bucket memory: one read/write port, registered read data.
// Entry is {tag, key}. Needs qph_pkg.
`default_nettype none
module qph_store #(
  parameter int MAX_BUCKETS = qph_pkg::MAX_BUCKETS_DEF,
  parameter int AW          = 6
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [AW-1:0]              addr,
  input  wire logic [qph_pkg::ENTRY_W-1:0] wdata,
  output logic      [qph_pkg::ENTRY_W-1:0] rdata
);
  import qph_pkg::*;

  logic [ENTRY_W-1:0] mem [MAX_BUCKETS];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> rtl/core/qph_seq.sv
// Command sequencer: key mod capacity by long division, probe walk,
// index scan, clear sweep and result register. Needs qph_pkg, qph_modstep.
`default_nettype none
module qph_seq #(
  parameter int MAX_BUCKETS = qph_pkg::MAX_BUCKETS_DEF,
  parameter int AW          = 6,
  parameter int CW          = 7
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [CW-1:0]                 cap,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [qph_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic [qph_pkg::KEY_W-1:0]     in_key,
  output logic                               mem_we,
  output logic      [AW-1:0]                 mem_addr,
  output logic      [qph_pkg::ENTRY_W-1:0]   mem_wdata,
  input  wire logic [qph_pkg::ENTRY_W-1:0]   mem_rdata,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output qph_pkg::result_t                   out_data
);
  import qph_pkg::*;

  seq_state_t state, state_next;

  logic [CMD_W-1:0]    cmd, cmd_next;
  logic [KEY_W-1:0]    key, key_next;
  logic [KEY_W-1:0]    shreg, shreg_next;
  logic [BITCNT_W-1:0] bitcnt, bitcnt_next;
  logic [CW-1:0]       rem, rem_next;
  logic [AW-1:0]       pos, pos_next;
  logic [CW-1:0]       idx, idx_next;
  logic [CW-1:0]       delta, delta_next;
  logic [CW-1:0]       count, count_next;
  logic                res_found, res_found_next;
  logic [AW-1:0]       res_slot, res_slot_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic                out_valid_next;
  result_t             out_data_next;

  logic [CW:0]         unit_a;
  logic [CW-1:0]       unit_y;
  logic [CW:0]         dsum;
  logic [CW-1:0]       delta_wrap;
  logic [TAG_W-1:0]    rd_tag;
  logic [KEY_W-1:0]    rd_key;
  logic                key_match, last_probe, sweep_last, out_free;
  logic                hit, stop_empty, finish;

  assign rd_tag     = mem_rdata[ENTRY_W-1 -: TAG_W];
  assign rd_key     = mem_rdata[KEY_W-1:0];
  assign key_match  = (rd_tag == TAG_LIVE) && (rd_key == key);
  assign last_probe = (idx == cap - CW'(1));
  assign sweep_last = (pos == AW'(MAX_BUCKETS - 1));
  assign out_free   = !out_valid || out_ready;
  assign in_ready   = (state == SQ_IDLE);

  // shared unit: division step in SQ_DIV, probe wrap otherwise
  always_comb begin
    if (state == SQ_DIV) begin
      unit_a = {rem, shreg[KEY_W-1]};
    end else begin
      unit_a = (CW+1)'(pos) + (CW+1)'(delta);
    end
  end

  qph_modstep #(.CW(CW)) u_modstep (
    .a (unit_a),
    .m (cap),
    .y (unit_y)
  );

  // odd step increment, kept reduced mod capacity
  always_comb begin
    dsum = (CW+1)'(delta) + (CW+1)'(2);
    if (dsum >= (CW+1)'(cap)) begin
      delta_wrap = CW'(dsum - (CW+1)'(cap));
    end else begin
      delta_wrap = CW'(dsum);
    end
  end

  // bucket decision for the probe in flight
  always_comb begin
    hit        = 1'b0;
    stop_empty = 1'b0;
    case (cmd)
      CMD_INSERT: begin
        hit = (rd_tag != TAG_LIVE);
      end
      CMD_REMOVE, CMD_CONTAINS: begin
        hit        = key_match;
        stop_empty = (rd_tag == TAG_EMPTY);
      end
      default: begin
        hit = key_match;
      end
    endcase
    finish = hit || stop_empty || last_probe;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      SQ_INIT: begin
        if (sweep_last) state_next = SQ_IDLE;
      end
      SQ_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            CMD_INSERT, CMD_REMOVE, CMD_CONTAINS: state_next = SQ_DIV;
            CMD_SEARCH:                           state_next = SQ_READ;
            CMD_CLEAR:                            state_next = SQ_CLEAR;
            default:                              state_next = SQ_DONE;
          endcase
        end
      end
      SQ_DIV: begin
        if (bitcnt == '0) state_next = SQ_READ;
      end
      SQ_READ: begin
        state_next = SQ_CHECK;
      end
      SQ_CHECK: begin
        state_next = finish ? SQ_DONE : SQ_READ;
      end
      SQ_CLEAR: begin
        if (sweep_last) state_next = SQ_DONE;
      end
      SQ_DONE: begin
        if (out_free) state_next = SQ_IDLE;
      end
      default: state_next = SQ_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cmd_next        = cmd;
    key_next        = key;
    shreg_next      = shreg;
    bitcnt_next     = bitcnt;
    rem_next        = rem;
    pos_next        = pos;
    idx_next        = idx;
    delta_next      = delta;
    count_next      = count;
    res_found_next  = res_found;
    res_slot_next   = res_slot;
    res_status_next = res_status;
    mem_we          = 1'b0;
    mem_addr        = pos;
    mem_wdata       = '0;
    out_valid_next  = out_valid;
    out_data_next   = out_data;

    if (out_ready) out_valid_next = 1'b0;

    case (state)
      SQ_INIT: begin
        mem_we   = 1'b1;
        pos_next = pos + AW'(1);
      end
      SQ_IDLE: begin
        cmd_next        = in_cmd;
        key_next        = in_key;
        shreg_next      = in_key;
        bitcnt_next     = BITCNT_W'(DIV_STEPS - 1);
        rem_next        = '0;
        pos_next        = '0;
        idx_next        = '0;
        res_found_next  = 1'b0;
        res_slot_next   = '0;
        res_status_next = ST_OK;
        if (in_valid && in_cmd == CMD_CLEAR) count_next = '0;
      end
      SQ_DIV: begin
        rem_next    = unit_y;
        shreg_next  = shreg << 1;
        bitcnt_next = bitcnt - BITCNT_W'(1);
        if (bitcnt == '0) begin
          pos_next   = AW'(unit_y);
          idx_next   = '0;
          delta_next = CW'(1);
        end
      end
      SQ_CHECK: begin
        if (hit) begin
          res_found_next  = 1'b1;
          res_slot_next   = pos;
          res_status_next = ST_OK;
          if (cmd == CMD_INSERT) begin
            mem_we     = 1'b1;
            mem_wdata  = {TAG_LIVE, key};
            count_next = count + CW'(1);
          end else if (cmd == CMD_REMOVE) begin
            mem_we    = 1'b1;
            mem_wdata = {TAG_DELETED, rd_key};
            if (count != '0) count_next = count - CW'(1);
          end
        end else if (finish) begin
          res_status_next = (cmd == CMD_INSERT) ? ST_FULL : ST_MISS;
        end else begin
          idx_next = idx + CW'(1);
          if (cmd == CMD_SEARCH) begin
            pos_next = AW'(idx + CW'(1));
          end else begin
            pos_next   = AW'(unit_y);
            delta_next = delta_wrap;
          end
        end
      end
      SQ_CLEAR: begin
        mem_we   = 1'b1;
        pos_next = pos + AW'(1);
      end
      SQ_DONE: begin
        if (out_free) begin
          out_valid_next           = 1'b1;
          out_data_next.found      = res_found;
          out_data_next.slot_index = SLOT_W'(res_slot);
          out_data_next.status     = res_status;
          out_data_next.entry_count = COUNT_W'(count);
        end
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SQ_INIT;
      pos       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pos       <= pos_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
    cmd        <= cmd_next;
    key        <= key_next;
    shreg      <= shreg_next;
    bitcnt     <= bitcnt_next;
    rem        <= rem_next;
    idx        <= idx_next;
    delta      <= delta_next;
    res_found  <= res_found_next;
    res_slot   <= res_slot_next;
    res_status <= res_status_next;
    out_data   <= out_data_next;
  end
endmodule
`default_nettype wire

>>> rtl/core/quadratic_probe_hash_set_unit.sv
// Quadratic-probe hash set: stream in a command and key, get one result per command.
// Slave channel s_*: command and key. Master channel m_*: found, slot, status, count.
// The capacity register is written through cfg_we/cfg_wdata (clamped to 2..MAX_BUCKETS).
// One command is worked at a time; s_tready is high only while the sequencer is idle.
// Steps from the input transfer to the result showing on m_tvalid:
//   insert/remove/contains: key mod capacity by long division (one remainder bit a cycle
//     through the shared compare-subtract unit), then per probe a memory read, then a
//     check, up to capacity probes, then the handoff to the output register.
//   index search: per bucket scanned a read, then a check, then the handoff.
//   clear: a sweep over all MAX_BUCKETS buckets, one bucket a cycle, then the handoff.
//   unused command codes: straight to the handoff.
// The single memory port sets the probe rate: one bucket read per probe.
// After reset a sweep empties every bucket of the store before s_tready rises;
// configuration writes are taken meanwhile.
// Results sit in an output register, so a new command is accepted while a result waits;
// a stalled m_tready only holds the sequencer once its next result is ready.
// Depends on qph_pkg, qph_seq, qph_store, qph_modstep.
`default_nettype none
module quadratic_probe_hash_set_unit #(
  parameter int MAX_BUCKETS = qph_pkg::MAX_BUCKETS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [qph_pkg::CFG_W-1:0]         cfg_wdata,  // table_capacity
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [qph_pkg::IN_DATA_W-1:0]     s_tdata,    // command[2:0], key[33:3]
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [qph_pkg::OUT_DATA_W-1:0]    m_tdata     // found[0], slot_index[6:1],
                                                             // status[8:7], entry_count[15:9]
);
  import qph_pkg::*;

  localparam int AW = (MAX_BUCKETS > 2) ? $clog2(MAX_BUCKETS) : 1;
  localparam int CW = $clog2(MAX_BUCKETS + 1);

  logic [CFG_W-1:0]   table_capacity;
  logic [CW-1:0]      cap;
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [ENTRY_W-1:0] mem_wdata, mem_rdata;
  result_t            result;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_capacity <= CAP_RESET;
    end else if (cfg_we) begin
      table_capacity <= cfg_wdata;
    end
  end

  // clamp to 2 .. MAX_BUCKETS
  always_comb begin
    if (table_capacity < CFG_W'(2)) begin
      cap = CW'(2);
    end else if (int'(table_capacity) > MAX_BUCKETS) begin
      cap = CW'(MAX_BUCKETS);
    end else begin
      cap = CW'(table_capacity);
    end
  end

  qph_seq #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .AW          (AW),
    .CW          (CW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cap       (cap),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (s_tdata[CMD_W-1:0]),
    .in_key    (s_tdata[CMD_W +: KEY_W]),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (result)
  );

  qph_store #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .AW          (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign m_tdata = result;

  // one command at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a command is in progress");

  // found implies ok status
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result.found |-> result.status == ST_OK)
    else $error("found result without ok status");

  // a full table reports no slot
  a_full_no_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result.status == ST_FULL |-> !result.found && result.slot_index == '0)
    else $error("full status with slot or found set");

  // status code stays in range
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> result.status == ST_OK || result.status == ST_MISS
                 || result.status == ST_FULL)
    else $error("undefined status code");
endmodule
`default_nettype wire

>>> tb/tb_quadratic_probe_hash_set_unit.sv
// Self-checking bench for quadratic_probe_hash_set_unit: random and directed commands,
// capacity sweeps, in-order result checks against a behavioral hash set model.
// Depends on qph_pkg and the RTL top level only.
`default_nettype none
module tb_quadratic_probe_hash_set_unit;
  import qph_pkg::*;

  localparam int NBKT      = 64;
  localparam int CYC_LIMIT = 2000000;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [30:0] key;
  } op_t;

  typedef struct packed {
    logic       found;
    logic [5:0] slot;
    logic [1:0] status;
    logic [6:0] count;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  quadratic_probe_hash_set_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // model state
  tag_t        mdl_tag [NBKT];
  logic [30:0] mdl_key [NBKT];
  int unsigned mdl_live;
  logic [6:0]  mdl_cap;

  op_t      pending_ops[$];
  outcome_t expected_outcomes[$];
  int       mismatches = 0;
  bit       quiet = 1'b0;   // no idling in the final stretch
  int       cycles = 0;
  int       send_gap = 0;
  int       recv_gap = 0;

  function automatic int unsigned eff_cap();
    int unsigned c;
    c = 32'(mdl_cap);
    if (c < 2) c = 2;
    if (c > NBKT) c = NBKT;
    return c;
  endfunction

  function automatic int unsigned probe(logic [30:0] k, int unsigned i, int unsigned c);
    longint unsigned s;
    s = 64'(k) + 64'(i) * 64'(i);
    return 32'(s % 64'(c));
  endfunction

  // apply one command to the model and return its outcome
  function automatic outcome_t hash_set_apply(op_t op);
    outcome_t r;
    int unsigned c, b;
    bit hit;
    c = eff_cap();
    r = '0;
    hit = 1'b0;
    case (op.cmd)
      CMD_INSERT: begin
        r.status = ST_FULL;
        for (int unsigned i = 0; i < c && !hit; i++) begin
          b = probe(op.key, i, c);
          if (mdl_tag[b] != TAG_LIVE) begin
            mdl_tag[b] = TAG_LIVE;
            mdl_key[b] = op.key;
            mdl_live++;
            r.found = 1'b1; r.slot = b[5:0]; r.status = ST_OK;
            hit = 1'b1;
          end
        end
      end
      CMD_REMOVE, CMD_CONTAINS: begin
        r.status = ST_MISS;
        for (int unsigned i = 0; i < c && !hit; i++) begin
          b = probe(op.key, i, c);
          if (mdl_tag[b] == TAG_EMPTY) break;
          if (mdl_tag[b] == TAG_LIVE && mdl_key[b] == op.key) begin
            hit = 1'b1;
            r.found = 1'b1; r.slot = b[5:0]; r.status = ST_OK;
            if (op.cmd == CMD_REMOVE) begin
              mdl_tag[b] = TAG_DELETED;
              if (mdl_live > 0) mdl_live--;
            end
          end
        end
      end
      CMD_SEARCH: begin
        r.status = ST_MISS;
        for (int unsigned i = 0; i < c && !hit; i++) begin
          if (mdl_tag[i] == TAG_LIVE && mdl_key[i] == op.key) begin
            hit = 1'b1;
            r.found = 1'b1; r.slot = i[5:0]; r.status = ST_OK;
          end
        end
      end
      CMD_CLEAR: begin
        foreach (mdl_tag[i]) mdl_tag[i] = TAG_EMPTY;
        mdl_live = 0;
      end
      default: ;
    endcase
    r.count = mdl_live[6:0];
    return r;
  endfunction

  // driver: presents queued commands, random gaps between them
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_outcomes.push_back(hash_set_apply(pending_ops.pop_front()));
        if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 5);
      end
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, pending_ops[0].key, pending_ops[0].cmd};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor: random stalls, check against oldest expectation
  always @(posedge clk) begin
    outcome_t got, exp;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[0], m_tdata[6:1], m_tdata[8:7], m_tdata[15:9]};
        if (expected_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", m_tdata);
        end else begin
          exp = expected_outcomes.pop_front();
          if (got != exp) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: found %0d/%0d slot %0d/%0d status %0d/%0d count %0d/%0d",
                       exp.found, got.found, exp.slot, got.slot, exp.status, got.status,
                       exp.count, got.count);
          end
        end
        if (!quiet && $urandom_range(0, 4) == 0) recv_gap = $urandom_range(1, 5);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > CYC_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic add_op(input logic [2:0] c, input logic [30:0] k);
    op_t o;
    o.cmd = c; o.key = k;
    pending_ops.push_back(o);
  endtask

  // wait for all traffic to drain, then a quiet period for the block to finish
  task automatic drain();
    while (pending_ops.size() > 0 || expected_outcomes.size() > 0 || s_tvalid)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [6:0] c);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we    <= 1'b0;
    mdl_cap = c;
  endtask

  // a burst of mostly well-formed traffic on a small key pool
  task automatic random_phase(input int n);
    logic [30:0] pool[8];
    int r;
    foreach (pool[i]) pool[i] = 31'($urandom());
    if ($urandom_range(0, 1)) foreach (pool[i]) pool[i] = 31'($urandom_range(0, 200));
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40)      add_op(CMD_INSERT, pool[$urandom_range(0, 7)]);
      else if (r < 60) add_op(CMD_REMOVE, pool[$urandom_range(0, 7)]);
      else if (r < 75) add_op(CMD_CONTAINS, pool[$urandom_range(0, 7)]);
      else if (r < 88) add_op(CMD_SEARCH, pool[$urandom_range(0, 7)]);
      else if (r < 90) add_op(CMD_CLEAR, 31'($urandom()));
      else if (r < 93) add_op(3'($urandom_range(5, 7)), 31'($urandom()));
      else             add_op(3'($urandom_range(0, 3)), 31'($urandom()));
    end
  endtask

  initial begin
    logic [6:0] caps[10] = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd64, 7'd127, 7'd100, 7'd7, 7'd31, 7'd17};
    foreach (mdl_tag[i]) begin
      mdl_tag[i] = TAG_EMPTY;
      mdl_key[i] = '0;
    end
    mdl_live = 0;
    mdl_cap  = CAP_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, duplicates, tombstones, unused codes
    add_op(CMD_CONTAINS, 31'd5);
    add_op(CMD_INSERT, 31'd0);
    add_op(CMD_INSERT, 31'h7fffffff);
    add_op(CMD_INSERT, 31'd17);
    add_op(CMD_INSERT, 31'd17);
    add_op(CMD_CONTAINS, 31'd17);
    add_op(CMD_SEARCH, 31'd17);
    add_op(CMD_REMOVE, 31'd0);
    add_op(CMD_CONTAINS, 31'd17);
    add_op(CMD_REMOVE, 31'd0);
    add_op(CMD_SEARCH, 31'h7fffffff);
    add_op(CMD_INSERT, 31'd34);
    add_op(3'd5, 31'h2aaaaaaa);
    add_op(3'd7, 31'h55555555);
    add_op(CMD_CLEAR, 31'd0);
    add_op(CMD_SEARCH, 31'd17);
    drain();

    // fill a capacity-2 table past full
    set_capacity(7'd2);
    for (int i = 0; i < 4; i++) add_op(CMD_INSERT, 31'(i));
    add_op(CMD_REMOVE, 31'd1);
    add_op(CMD_INSERT, 31'd9);
    drain();

    // random phases across capacities, with table contents carried over
    for (int p = 0; p < 20; p++) begin
      set_capacity(p < 10 ? caps[p] : 7'($urandom_range(0, 127)));
      if (p == 19) quiet = 1'b1;
      random_phase(80);
      drain();
    end

    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire
